// ===== design/ckmd4_pkg.sv =====
`default_nettype none
package ckmd4_pkg;

    localparam logic [23:0] CHUNK_BYTES = 24'd9728000;

    localparam int RAM_WIDTH = 32;
    localparam int RAM_DEPTH = 32;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;

    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] LAST_STEP   = 6'd49;
    localparam logic [5:0] ROUND_STEPS = 6'd48;

    localparam logic RAM_AREA_CHUNK = 1'b0;
    localparam logic RAM_AREA_OUTER = 1'b1;

    typedef logic [3:0][31:0] chain_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLK,
        ST_FIN,
        ST_CPAD1,
        ST_CPAD2,
        ST_OWR,
        ST_OBLK,
        ST_OPAD1,
        ST_OPAD2,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        KIND_MID,
        KIND_DIRECT,
        KIND_FINAL
    } kind_t;

    // One compression job: which buffer area, how many stored bytes are message
    // data, whether the 0x80 marker follows them and whether the length words close it.
    typedef struct packed {
        logic        area;
        logic [6:0]  nbytes;
        logic        mark;
        logic        len_en;
        logic [63:0] len_bits;
        chain_t      chain;
    } req_t;

    function automatic chain_t chain_init();
        chain_t c;
        c[0] = IV0;
        c[1] = IV1;
        c[2] = IV2;
        c[3] = IV3;
        return c;
    endfunction

    function automatic logic [3:0] msg_index(input logic [1:0] grp, input logic [3:0] i);
        logic [3:0] k;
        unique case (grp)
            2'd0: k = i;
            2'd1: k = {i[1:0], i[3:2]};
            2'd2: k = {i[0], i[1], i[2], i[3]};
            default: k = 4'd0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] shift_amt(input logic [1:0] grp, input logic [1:0] j);
        logic [4:0] s;
        unique case ({grp, j})
            4'b0000: s = 5'd3;
            4'b0001: s = 5'd7;
            4'b0010: s = 5'd11;
            4'b0011: s = 5'd19;
            4'b0100: s = 5'd3;
            4'b0101: s = 5'd5;
            4'b0110: s = 5'd9;
            4'b0111: s = 5'd13;
            4'b1000: s = 5'd3;
            4'b1001: s = 5'd9;
            4'b1010: s = 5'd11;
            4'b1011: s = 5'd15;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] round_add(input logic [1:0] grp);
        logic [31:0] a;
        unique case (grp)
            2'd1: a = 32'h5A827999;
            2'd2: a = 32'h6ED9EBA1;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage
`default_nettype wire

// ===== design/ckmd4_ram.sv =====
`default_nettype none
module ckmd4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== design/ckmd4_core.sv =====
`default_nettype none
module ckmd4_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       go,
    input  wire ckmd4_pkg::req_t            req,
    output logic [ckmd4_pkg::RAM_AW-1:0]    rd_addr,
    input  wire logic [31:0]                rd_data,
    output logic                            done,
    output ckmd4_pkg::chain_t               result
);

    logic              busy_reg, busy_next;
    logic [5:0]        p_reg, p_next;
    logic [3:0]        k_reg, k_next;
    ckmd4_pkg::req_t   req_reg, req_next;
    ckmd4_pkg::chain_t v_reg, v_next;

    logic [5:0]  rnd;
    logic [31:0] w;
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot;
    logic [6:0]  idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            p_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            p_reg    <= p_next;
        end
        k_reg   <= k_next;
        req_reg <= req_next;
        v_reg   <= v_next;
    end

    always_comb begin
        busy_next = busy_reg;
        p_next    = p_reg;
        req_next  = req_reg;
        v_next    = v_reg;
        rnd       = p_reg - 6'd1;

        // Word index fetched this cycle, data returns next cycle.
        k_next  = ckmd4_pkg::msg_index(p_reg[5:4], p_reg[3:0]);
        rd_addr = {req_reg.area, k_next};

        // Build the message word: stored bytes, then marker, zeros and length.
        for (int b = 0; b < 4; b++) begin
            idx = {1'b0, k_reg, 2'(b)};
            if (idx < req_reg.nbytes) begin
                w[8*b +: 8] = rd_data[8*b +: 8];
            end else if (req_reg.mark && idx == req_reg.nbytes) begin
                w[8*b +: 8] = 8'h80;
            end else begin
                w[8*b +: 8] = 8'h00;
            end
        end
        if (req_reg.len_en && k_reg == 4'd14) begin
            w = req_reg.len_bits[31:0];
        end else if (req_reg.len_en && k_reg == 4'd15) begin
            w = req_reg.len_bits[63:32];
        end

        unique case (rnd[5:4])
            2'd0: f = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            2'd1: f = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3]) | (v_reg[2] & v_reg[3]);
            default: f = v_reg[1] ^ v_reg[2] ^ v_reg[3];
        endcase
        sum = v_reg[0] + f + w + ckmd4_pkg::round_add(rnd[5:4]);
        rot = {sum, sum} << ckmd4_pkg::shift_amt(rnd[5:4], rnd[1:0]);

        done = busy_reg && p_reg == ckmd4_pkg::LAST_STEP;
        for (int i = 0; i < 4; i++) begin
            result[i] = req_reg.chain[i] + v_reg[i];
        end

        if (go) begin
            busy_next = 1'b1;
            p_next    = '0;
            req_next  = req;
            v_next    = req.chain;
        end else if (busy_reg) begin
            if (p_reg != 6'd0 && p_reg <= ckmd4_pkg::ROUND_STEPS) begin
                v_next[0] = v_reg[3];
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = rot[63:32];
            end
            if (done) begin
                busy_next = 1'b0;
            end else begin
                p_next = p_reg + 6'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/chunked_md4_list_hash_top.sv =====
`default_nettype none
// Channel  | Ports                          | Contents
// ---------+--------------------------------+-----------------------------------------
// input    | s_tvalid s_tready s_tdata      | one file byte, byte-valid flag, end flag
//          | s_tuser s_tlast                |
// output   | m_tvalid m_tready m_tdata      | one 64-bit digest half, last-half flag
//          | m_tlast                        |
//
// An item without a block boundary is taken without stalling the input. Every
// 64th byte of a chunk runs one MD4 compression through the shared round unit and
// holds the input while the unit starts, fetches the first message word from the
// block buffer RAM, runs 48 round steps and adds the chaining values.
// A chunk close costs one or two compressions, four RAM writes and possibly one
// outer compression. At the end of the file the FIN state picks the path: a file
// below one chunk pads its chunk with one or two compressions, while any other file
// closes its last chunk as above and adds one outer padding compression; then the
// two halves follow. Reset is synchronous and active low and restores the initial
// chaining values; no clearing pass is needed. The input is stalled outside the idle
// state: while any compression runs, while digest words go to the outer buffer and
// while the digest waits on the output; the next file starts after its second half.
module chunked_md4_list_hash_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] byte_valid
    input  wire logic        s_tlast,   // end_of_file
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] digest_half
    output logic             m_tlast    // last_half
);

    ckmd4_pkg::state_t state_reg, state_next;
    ckmd4_pkg::kind_t  kind_reg, kind_next;
    logic              eof_reg, eof_next;
    logic              go_reg, go_next;
    logic              half_reg, half_next;
    logic [1:0]        owr_cnt_reg, owr_cnt_next;
    ckmd4_pkg::chain_t chunk_chain_reg, chunk_chain_next;
    ckmd4_pkg::chain_t outer_chain_reg, outer_chain_next;
    ckmd4_pkg::chain_t dig_reg, dig_next;
    logic [63:0]       obt_reg, obt_next;
    logic [63:0]       total_reg, total_next;
    logic [23:0]       bic_reg, bic_next;
    logic [31:0]       acc_reg, acc_next;

    logic                         wr_en;
    logic [ckmd4_pkg::RAM_AW-1:0] wr_addr;
    logic [31:0]                  wr_data;
    logic [ckmd4_pkg::RAM_AW-1:0] rd_addr;
    logic [31:0]                  rd_data;
    ckmd4_pkg::req_t              req;
    logic                         eng_done;
    ckmd4_pkg::chain_t            eng_result;
    logic [23:0]                  bic_inc;
    logic                         comp_next;

    ckmd4_ram #(
        .WIDTH(ckmd4_pkg::RAM_WIDTH),
        .DEPTH(ckmd4_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ckmd4_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (go_reg),
        .req     (req),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (eng_done),
        .result  (eng_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ckmd4_pkg::ST_IDLE;
            kind_reg        <= ckmd4_pkg::KIND_MID;
            eof_reg         <= 1'b0;
            go_reg          <= 1'b0;
            half_reg        <= 1'b0;
            owr_cnt_reg     <= '0;
            chunk_chain_reg <= ckmd4_pkg::chain_init();
            outer_chain_reg <= ckmd4_pkg::chain_init();
            obt_reg         <= '0;
            total_reg       <= '0;
            bic_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            eof_reg         <= eof_next;
            go_reg          <= go_next;
            half_reg        <= half_next;
            owr_cnt_reg     <= owr_cnt_next;
            chunk_chain_reg <= chunk_chain_next;
            outer_chain_reg <= outer_chain_next;
            obt_reg         <= obt_next;
            total_reg       <= total_next;
            bic_reg         <= bic_next;
        end
        dig_reg <= dig_next;
        acc_reg <= acc_next;
    end

    // Compression job for the state that is running.
    always_comb begin
        req.area     = ckmd4_pkg::RAM_AREA_CHUNK;
        req.nbytes   = ckmd4_pkg::BLOCK_BYTES;
        req.mark     = 1'b0;
        req.len_en   = 1'b0;
        req.len_bits = {37'd0, bic_reg, 3'd0};
        req.chain    = chunk_chain_reg;
        unique case (state_reg)
            ckmd4_pkg::ST_CPAD1: begin
                req.nbytes = {1'b0, bic_reg[5:0]};
                req.mark   = 1'b1;
                req.len_en = bic_reg[5:0] < ckmd4_pkg::LEN_POS;
            end
            ckmd4_pkg::ST_CPAD2: begin
                req.nbytes = '0;
                req.len_en = 1'b1;
                req.chain  = dig_reg;
            end
            ckmd4_pkg::ST_OBLK: begin
                req.area  = ckmd4_pkg::RAM_AREA_OUTER;
                req.chain = outer_chain_reg;
            end
            ckmd4_pkg::ST_OPAD1: begin
                req.area     = ckmd4_pkg::RAM_AREA_OUTER;
                req.nbytes   = {1'b0, obt_reg[5:0]};
                req.mark     = 1'b1;
                req.len_en   = obt_reg[5:0] < ckmd4_pkg::LEN_POS;
                req.len_bits = {obt_reg[60:0], 3'd0};
                req.chain    = outer_chain_reg;
            end
            ckmd4_pkg::ST_OPAD2: begin
                req.area     = ckmd4_pkg::RAM_AREA_OUTER;
                req.nbytes   = '0;
                req.len_en   = 1'b1;
                req.len_bits = {obt_reg[60:0], 3'd0};
                req.chain    = dig_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        eof_next         = eof_reg;
        half_next        = half_reg;
        owr_cnt_next     = owr_cnt_reg;
        chunk_chain_next = chunk_chain_reg;
        outer_chain_next = outer_chain_reg;
        dig_next         = dig_reg;
        obt_next         = obt_reg;
        total_next       = total_reg;
        bic_next         = bic_reg;
        acc_next         = acc_reg;
        wr_en            = 1'b0;
        wr_addr          = {ckmd4_pkg::RAM_AREA_CHUNK, bic_reg[5:2]};
        wr_data          = acc_reg;
        bic_inc          = bic_reg + 24'd1;

        s_tready = state_reg == ckmd4_pkg::ST_IDLE;
        m_tvalid = state_reg == ckmd4_pkg::ST_OUT;
        m_tlast  = half_reg;
        m_tdata  = half_reg ? {ckmd4_pkg::bswap(dig_reg[2]), ckmd4_pkg::bswap(dig_reg[3])}
                            : {ckmd4_pkg::bswap(dig_reg[0]), ckmd4_pkg::bswap(dig_reg[1])};

        unique case (state_reg)
            ckmd4_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    eof_next = s_tlast;
                    if (s_tuser) begin
                        // Bytes land in order, so the word register always holds
                        // the earlier bytes of the word being written.
                        if (bic_reg[1:0] == 2'd0) begin
                            acc_next = {24'd0, s_tdata};
                        end else begin
                            acc_next = acc_reg | (32'(s_tdata) << {bic_reg[1:0], 3'd0});
                        end
                        wr_en      = 1'b1;
                        wr_data    = acc_next;
                        bic_next   = bic_inc;
                        total_next = total_reg + 64'd1;
                        if (bic_inc[5:0] == 6'd0) begin
                            state_next = ckmd4_pkg::ST_BLK;
                        end else if (bic_inc >= ckmd4_pkg::CHUNK_BYTES) begin
                            state_next = ckmd4_pkg::ST_CPAD1;
                            kind_next  = ckmd4_pkg::KIND_MID;
                        end else if (s_tlast) begin
                            state_next = ckmd4_pkg::ST_FIN;
                        end
                    end else if (s_tlast) begin
                        state_next = ckmd4_pkg::ST_FIN;
                    end
                end
            end
            ckmd4_pkg::ST_BLK: begin
                if (eng_done) begin
                    chunk_chain_next = eng_result;
                    if (bic_reg >= ckmd4_pkg::CHUNK_BYTES) begin
                        state_next = ckmd4_pkg::ST_CPAD1;
                        kind_next  = ckmd4_pkg::KIND_MID;
                    end else if (eof_reg) begin
                        state_next = ckmd4_pkg::ST_FIN;
                    end else begin
                        state_next = ckmd4_pkg::ST_IDLE;
                    end
                end
            end
            ckmd4_pkg::ST_FIN: begin
                // A file shorter than one chunk gives the chunk digest directly.
                state_next = ckmd4_pkg::ST_CPAD1;
                if (total_reg < 64'(ckmd4_pkg::CHUNK_BYTES)) begin
                    kind_next = ckmd4_pkg::KIND_DIRECT;
                end else begin
                    kind_next = ckmd4_pkg::KIND_FINAL;
                end
            end
            ckmd4_pkg::ST_CPAD1, ckmd4_pkg::ST_CPAD2: begin
                if (eng_done) begin
                    dig_next = eng_result;
                    if (state_reg == ckmd4_pkg::ST_CPAD1 &&
                        bic_reg[5:0] >= ckmd4_pkg::LEN_POS) begin
                        state_next = ckmd4_pkg::ST_CPAD2;
                    end else if (kind_reg == ckmd4_pkg::KIND_DIRECT) begin
                        state_next = ckmd4_pkg::ST_OUT;
                        half_next  = 1'b0;
                    end else begin
                        state_next   = ckmd4_pkg::ST_OWR;
                        owr_cnt_next = '0;
                    end
                end
            end
            ckmd4_pkg::ST_OWR: begin
                // Chunk digest words go to the outer buffer, one per cycle.
                wr_en        = 1'b1;
                wr_addr      = {ckmd4_pkg::RAM_AREA_OUTER, obt_reg[5:4], owr_cnt_reg};
                wr_data      = dig_reg[owr_cnt_reg];
                owr_cnt_next = owr_cnt_reg + 2'd1;
                if (owr_cnt_reg == 2'd3) begin
                    obt_next         = obt_reg + 64'd16;
                    chunk_chain_next = ckmd4_pkg::chain_init();
                    bic_next         = '0;
                    if (obt_reg[5:4] == 2'd3) begin
                        state_next = ckmd4_pkg::ST_OBLK;
                    end else if (kind_reg == ckmd4_pkg::KIND_FINAL) begin
                        state_next = ckmd4_pkg::ST_OPAD1;
                    end else if (eof_reg) begin
                        state_next = ckmd4_pkg::ST_FIN;
                    end else begin
                        state_next = ckmd4_pkg::ST_IDLE;
                    end
                end
            end
            ckmd4_pkg::ST_OBLK: begin
                if (eng_done) begin
                    outer_chain_next = eng_result;
                    if (kind_reg == ckmd4_pkg::KIND_FINAL) begin
                        state_next = ckmd4_pkg::ST_OPAD1;
                    end else if (eof_reg) begin
                        state_next = ckmd4_pkg::ST_FIN;
                    end else begin
                        state_next = ckmd4_pkg::ST_IDLE;
                    end
                end
            end
            ckmd4_pkg::ST_OPAD1, ckmd4_pkg::ST_OPAD2: begin
                if (eng_done) begin
                    dig_next = eng_result;
                    if (state_reg == ckmd4_pkg::ST_OPAD1 &&
                        obt_reg[5:0] >= ckmd4_pkg::LEN_POS) begin
                        state_next = ckmd4_pkg::ST_OPAD2;
                    end else begin
                        state_next = ckmd4_pkg::ST_OUT;
                        half_next  = 1'b0;
                    end
                end
            end
            ckmd4_pkg::ST_OUT: begin
                if (m_tready) begin
                    if (half_reg) begin
                        // Digest delivered: start a fresh file.
                        state_next       = ckmd4_pkg::ST_IDLE;
                        half_next        = 1'b0;
                        eof_next         = 1'b0;
                        chunk_chain_next = ckmd4_pkg::chain_init();
                        outer_chain_next = ckmd4_pkg::chain_init();
                        obt_next         = '0;
                        total_next       = '0;
                        bic_next         = '0;
                    end else begin
                        half_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ckmd4_pkg::ST_IDLE;
            end
        endcase

        comp_next = state_next == ckmd4_pkg::ST_BLK   || state_next == ckmd4_pkg::ST_CPAD1 ||
                    state_next == ckmd4_pkg::ST_CPAD2 || state_next == ckmd4_pkg::ST_OBLK  ||
                    state_next == ckmd4_pkg::ST_OPAD1 || state_next == ckmd4_pkg::ST_OPAD2;
        go_next   = comp_next && state_next != state_reg;
    end

endmodule
`default_nettype wire
